// File: rtl/bved_pkg.sv
package bved_pkg;

  // Field widths fixed by the programming model.
  localparam int unsigned PREFIX_W  = 7;
  localparam int unsigned MD_W      = 6;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SCORE_W   = 7;

  // Number of match-vector registers in the register map.
  localparam int unsigned NUM_EQ_REGS = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EQ_BASE        = 3'd2;

  localparam logic [PREFIX_W-1:0] LENGTH_RESET = 7'd64;

  // Result codes.
  localparam logic [1:0] OUTCOME_CONTINUE = 2'd0;
  localparam logic [1:0] OUTCOME_FAILURE  = 2'd1;
  localparam logic [1:0] OUTCOME_SUCCESS  = 2'd2;
  localparam logic [1:0] OUTCOME_REJECTED = 2'd3;

  typedef struct packed {
    logic [1:0] symbol;
    logic       is_wildcard;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]          outcome;
    logic [PREFIX_W-1:0] prefix_end;
  } out_beat_t;

  // Command to the backward scan unit.
  typedef struct packed {
    logic                go;
    logic [PREFIX_W-1:0] from;
    logic [MD_W-1:0]     max_dist;
  } scan_cmd_t;

  // Answer from the backward scan unit.
  typedef struct packed {
    logic                done;
    logic                found;
    logic [PREFIX_W-1:0] pos;
  } scan_rsp_t;

endpackage

// File: rtl/bit_vector_edit_distance_column.sv
// Bit-parallel edit-distance column against a programmed pattern.
// Software first writes pattern_length, max_distance and the four match
// vectors through the write port (cfg_we_i, cfg_idx_i, cfg_data_i), only
// while the block is idle. Each input beat on in_valid_i/in_stall_o carries
// one text symbol; the block answers with exactly one output beat on
// out_valid_o/out_stall_i giving the outcome and the current prefix end.
// The beat is registered at acceptance, the column update follows, and a
// result is staged and then shows on the output register. When the prefix
// end shrinks, a backward scan walks one pattern row per cycle from the old
// prefix end down before the result is staged; an item with a scan takes
// longer, and the scan unit sets the worst case.
// One item is worked on at a time: in_stall_o is high from acceptance until
// the result has moved into the output register. A result waiting in the
// output register does not hold back the next input beat; the next result
// waits in its staging register while out_stall_i is high.
// Reset clears the column to all plus bits, no minus bits, prefix end zero,
// and loads the register reset values; no clearing pass is needed.
module bit_vector_edit_distance_column import bved_pkg::*; #(
  parameter int unsigned PATTERN_BITS  = 64,
  parameter int unsigned ALPHABET_SIZE = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned PW = $clog2(PATTERN_BITS);
  // Symbol codes at or above the alphabet size never match, so only the
  // vectors of codes below it are stored.
  localparam int unsigned NUM_STORED =
    (ALPHABET_SIZE < NUM_EQ_REGS) ? ALPHABET_SIZE : NUM_EQ_REGS;
  localparam int unsigned SYM_W = (NUM_STORED > 1) ? $clog2(NUM_STORED) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Configuration registers.
  logic [PREFIX_W-1:0]     length_q;
  logic [MD_W-1:0]         md_q;
  logic [PATTERN_BITS-1:0] eq_q [NUM_STORED];

  // Column state and sequencer.
  state_e                  state_q, state_d;
  logic [PATTERN_BITS-1:0] plus_q, plus_d;
  logic [PATTERN_BITS-1:0] minus_q, minus_d;
  logic [PREFIX_W-1:0]     best_q, best_d;
  logic                    ended_q, ended_d;
  in_beat_t                item_q, item_d;
  out_beat_t               res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  out_beat_t               out_data_q, out_data_d;

  // Datapath signals.
  logic [PREFIX_W-1:0]     len_eff;
  logic [PATTERN_BITS-1:0] len_mask;
  logic [PATTERN_BITS-1:0] eq_sel;
  logic [PATTERN_BITS-1:0] pv_eff;
  logic [PATTERN_BITS-1:0] mv_eff;
  logic [PREFIX_W-1:0]     bp_eff;
  logic                    ended_eff;
  logic [PW-1:0]           bp_idx;
  logic [PREFIX_W-1:0]     bp_next;
  logic [PATTERN_BITS-1:0] pv_new;
  logic [PATTERN_BITS-1:0] mv_new;
  logic [PATTERN_BITS-1:0] ph_new;
  logic [PATTERN_BITS-1:0] mh_new;
  logic                    out_free;
  scan_cmd_t               scan_cmd;
  scan_rsp_t               scan_rsp;

  // Configuration writes. Indexes past the stored vectors are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= LENGTH_RESET;
      md_q     <= '0;
      for (int k = 0; k < NUM_STORED; k++) begin
        eq_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_PATTERN_LENGTH) begin
        length_q <= cfg_data_i[PREFIX_W-1:0];
      end
      if (cfg_idx_i == REG_MAX_DISTANCE) begin
        md_q <= cfg_data_i[MD_W-1:0];
      end
      for (int k = 0; k < NUM_STORED; k++) begin
        if (cfg_idx_i == REG_EQ_BASE + CFG_IDX_W'(k)) begin
          eq_q[k] <= cfg_data_i[PATTERN_BITS-1:0];
        end
      end
    end
  end

  // Pattern length in use: zero counts as one, and the length is capped at
  // the vector width.
  always_comb begin
    if (length_q == '0) begin
      len_eff = PREFIX_W'(1);
    end else if (length_q > PREFIX_W'(PATTERN_BITS)) begin
      len_eff = PREFIX_W'(PATTERN_BITS);
    end else begin
      len_eff = length_q;
    end
    for (int i = 0; i < PATTERN_BITS; i++) begin
      len_mask[i] = PREFIX_W'(i) < len_eff;
    end
  end

  // Match vector of the current symbol; a wildcard or an unused code
  // matches no row.
  always_comb begin
    eq_sel = '0;
    if (!item_q.is_wildcard && (32'(item_q.symbol) < NUM_STORED)) begin
      eq_sel = eq_q[item_q.symbol[SYM_W-1:0]] & len_mask;
    end
  end

  // A restart takes effect before the symbol is applied.
  always_comb begin
    pv_eff    = item_q.restart ? '1 : plus_q;
    mv_eff    = item_q.restart ? '0 : minus_q;
    bp_eff    = item_q.restart ? PREFIX_W'(md_q) : best_q;
    ended_eff = item_q.restart ? 1'b0 : ended_q;
    bp_idx    = bp_eff[PW-1:0];
    bp_next   = bp_eff + PREFIX_W'(1);
  end

  bved_update #(
    .PATTERN_BITS(PATTERN_BITS)
  ) u_update (
    .eq_i (eq_sel),
    .pv_i (pv_eff),
    .mv_i (mv_eff),
    .pv_o (pv_new),
    .mv_o (mv_new),
    .ph_o (ph_new),
    .mh_o (mh_new)
  );

  // The scan reads the column registers, which already hold the updated
  // vectors by the time it takes its first step.
  bved_scan #(
    .PATTERN_BITS(PATTERN_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (scan_cmd),
    .plus_i  (plus_q),
    .minus_i (minus_q),
    .rsp_o   (scan_rsp)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    plus_d      = plus_q;
    minus_d     = minus_q;
    best_d      = best_q;
    ended_d     = ended_q;
    item_d      = item_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    scan_cmd    = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        state_d = ST_EMIT;
        if (ended_eff) begin
          // The column already ended and no restart came: state is kept.
          res_d.outcome    = OUTCOME_REJECTED;
          res_d.prefix_end = '0;
        end else begin
          plus_d  = pv_eff;
          minus_d = mv_eff;
          best_d  = bp_eff;
          ended_d = 1'b0;
          if (bp_eff >= len_eff) begin
            // The whole pattern is already within the threshold.
            ended_d          = 1'b1;
            res_d.outcome    = OUTCOME_SUCCESS;
            res_d.prefix_end = len_eff;
          end else begin
            plus_d  = pv_new;
            minus_d = mv_new;
            if (eq_sel[bp_idx] || mh_new[bp_idx]) begin
              best_d = bp_next;
              if (bp_next >= len_eff) begin
                ended_d       = 1'b1;
                res_d.outcome = OUTCOME_SUCCESS;
              end else begin
                res_d.outcome = OUTCOME_CONTINUE;
              end
              res_d.prefix_end = bp_next;
            end else if (ph_new[bp_idx]) begin
              // The distance at the old prefix end went over the threshold.
              scan_cmd.go       = 1'b1;
              scan_cmd.from     = bp_eff;
              scan_cmd.max_dist = md_q;
              state_d           = ST_SCAN;
            end else begin
              res_d.outcome    = OUTCOME_CONTINUE;
              res_d.prefix_end = bp_eff;
            end
          end
        end
      end

      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_d = ST_EMIT;
          if (scan_rsp.found) begin
            best_d           = scan_rsp.pos;
            res_d.outcome    = OUTCOME_CONTINUE;
            res_d.prefix_end = scan_rsp.pos;
          end else begin
            best_d           = '0;
            ended_d          = 1'b1;
            res_d.outcome    = OUTCOME_FAILURE;
            res_d.prefix_end = '0;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plus_q      <= '1;
      minus_q     <= '0;
      best_q      <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plus_q      <= plus_d;
      minus_q     <= minus_d;
      best_q      <= best_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // The scan unit only answers while the sequencer waits for it.
  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> (state_q == ST_SCAN))
    else $error("scan unit finished outside the scan state");

  // A column only ends together with a result on its way out.
  a_end_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ended_q) |-> (state_q == ST_EMIT))
    else $error("column ended without a staged result");

  // A failure never reports a prefix.
  a_failure_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.outcome == OUTCOME_FAILURE))
      |-> (out_data_o.prefix_end == '0))
    else $error("failure beat carries a nonzero prefix end");
`endif

endmodule

// File: rtl/bved_update.sv
module bved_update import bved_pkg::*; #(
  parameter int unsigned PATTERN_BITS = 64
) (
  input  logic [PATTERN_BITS-1:0] eq_i,
  input  logic [PATTERN_BITS-1:0] pv_i,
  input  logic [PATTERN_BITS-1:0] mv_i,
  output logic [PATTERN_BITS-1:0] pv_o,
  output logic [PATTERN_BITS-1:0] mv_o,
  output logic [PATTERN_BITS-1:0] ph_o,
  output logic [PATTERN_BITS-1:0] mh_o
);

  logic [PATTERN_BITS-1:0] xv;
  logic [PATTERN_BITS-1:0] xh;
  logic [PATTERN_BITS-1:0] sum;
  logic [PATTERN_BITS-1:0] ph_raw;
  logic [PATTERN_BITS-1:0] ph_sh;

  // One column step of the bit-vector recurrence; the carry chain of the
  // add is the only long path.
  always_comb begin
    xv     = eq_i | mv_i;
    sum    = (eq_i & pv_i) + pv_i;
    xh     = (sum ^ pv_i) | eq_i;
    ph_raw = mv_i | ~(xh | pv_i);
    mh_o   = pv_i & xh;
    ph_sh  = {ph_raw[PATTERN_BITS-2:0], 1'b1};
    ph_o   = ph_sh;
    pv_o   = {mh_o[PATTERN_BITS-2:0], 1'b0} | ~(xv | ph_sh);
    mv_o   = ph_sh & xv;
  end

endmodule

// File: rtl/bved_scan.sv
module bved_scan import bved_pkg::*; #(
  parameter int unsigned PATTERN_BITS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scan_cmd_t               cmd_i,
  input  logic [PATTERN_BITS-1:0] plus_i,
  input  logic [PATTERN_BITS-1:0] minus_i,
  output scan_rsp_t               rsp_o
);

  localparam int unsigned PW = $clog2(PATTERN_BITS);

  logic               busy_q, busy_d;
  logic [PW-1:0]      idx_q, idx_d;
  logic [SCORE_W-1:0] score_q, score_d;
  logic [MD_W-1:0]    md_q, md_d;
  logic [PW-1:0]      pos;
  logic [SCORE_W-1:0] step;

  // One row per cycle, walking toward row zero. The score moves by one
  // through a single shared adder.
  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    score_d = score_q;
    md_d    = md_q;
    rsp_o   = '0;
    pos     = idx_q - PW'(1);
    step    = plus_i[pos] ? {SCORE_W{1'b1}} : SCORE_W'(1);
    if (cmd_i.go) begin
      busy_d  = 1'b1;
      idx_d   = cmd_i.from[PW-1:0];
      md_d    = cmd_i.max_dist;
      score_d = SCORE_W'({1'b0, cmd_i.max_dist}) + SCORE_W'(1);
    end else if (busy_q) begin
      if (idx_q == '0) begin
        rsp_o.done = 1'b1;
        busy_d     = 1'b0;
      end else begin
        idx_d = pos;
        if (plus_i[pos] || minus_i[pos]) begin
          score_d = score_q + step;
        end
        if (plus_i[pos] && ((score_q + step) <= SCORE_W'({1'b0, md_q}))) begin
          rsp_o.done  = 1'b1;
          rsp_o.found = 1'b1;
          rsp_o.pos   = PREFIX_W'(pos);
          busy_d      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    score_q <= score_d;
    md_q    <= md_d;
  end

endmodule

// File: tb/tb.sv
module tb;
  import bved_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PATTERN_BITS  = 64;
  localparam int unsigned ALPHABET_SIZE = 4;

  // Longest run of cycles in which neither channel moves a beat. A correct
  // item needs at most one sender gap, its pass through the block and one
  // receiver stall burst, so this is several times the worst case.
  localparam int unsigned STALL_LIMIT = 1000;

  // Number of input beats after which the random part stops.
  localparam int unsigned ITEM_TARGET = 1900;

  // Near the end all idling is switched off.
  localparam int unsigned CALM_FROM = 1650;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_beat_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_beat_t            out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  bit_vector_edit_distance_column #(
    .PATTERN_BITS (PATTERN_BITS),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. The register copies follow every write on the config
  // port; the column copies follow every accepted input beat.
  // ---------------------------------------------------------------------------
  logic [PREFIX_W-1:0]     len_reg = LENGTH_RESET;
  logic [MD_W-1:0]         maxd_reg = '0;
  logic [CFG_W-1:0]        eq_regs [NUM_EQ_REGS] = '{default: '0};
  logic [PATTERN_BITS-1:0] plus_col = '1;
  logic [PATTERN_BITS-1:0] minus_col = '0;
  logic [PREFIX_W-1:0]     prefix_best = '0;
  logic                    col_ended = 1'b0;

  // Pattern symbols behind the match vectors, used to build text that
  // resembles the pattern.
  logic [1:0] pat [PATTERN_BITS];

  // Beats waiting to be driven, and results owed by the block, oldest first.
  in_beat_t  pending_beats [$];
  out_beat_t results_due [$];

  // Beats queued but not yet accepted; it drops only at the rising edge when
  // a beat is taken, so the stimulus can read it safely at the falling edge.
  int unsigned beats_open = 0;
  int unsigned beats_total = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Percent chance per cycle that a side starts an idle burst.
  int unsigned idle_pct = 0;

  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic        in_taken = 1'b0;

  // A length of zero behaves as one, anything past the vector width as the
  // full width.
  function automatic int eff_len(input logic [PREFIX_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > PATTERN_BITS) return PATTERN_BITS;
    return raw;
  endfunction

  // Advances the predicted column by one text symbol and returns the result
  // beat that the block owes for it.
  function automatic out_beat_t advance_column(input in_beat_t beat);
    out_beat_t               res;
    int                      m;
    int                      idx;
    int                      score;
    logic                    found;
    logic [PREFIX_W-1:0]     bp;
    logic [PATTERN_BITS-1:0] len_mask, eq, xv, xh, ph, mh, pv, mv;

    m = eff_len(len_reg);
    len_mask = {PATTERN_BITS{1'b1}} >> (PATTERN_BITS - m);

    // A restart puts the column back to its starting shape before the
    // symbol is applied.
    if (beat.restart) begin
      plus_col = '1;
      minus_col = '0;
      prefix_best = PREFIX_W'(maxd_reg);
      col_ended = 1'b0;
    end

    // Once a column has ended, symbols are turned away without any change.
    if (col_ended) begin
      res.outcome = OUTCOME_REJECTED;
      res.prefix_end = '0;
      return res;
    end

    // The whole pattern is already within reach: succeed without touching
    // the column.
    if (prefix_best >= m) begin
      col_ended = 1'b1;
      res.outcome = OUTCOME_SUCCESS;
      res.prefix_end = m[PREFIX_W-1:0];
      return res;
    end

    eq = '0;
    if (!beat.is_wildcard && beat.symbol < ALPHABET_SIZE && beat.symbol < NUM_EQ_REGS)
      eq = eq_regs[beat.symbol] & len_mask;

    pv = plus_col;
    mv = minus_col;
    xv = eq | mv;
    xh = (((eq & pv) + pv) ^ pv) | eq;
    ph = mv | ~(xh | pv);
    mh = pv & xh;
    ph = (ph << 1) | {{(PATTERN_BITS-1){1'b0}}, 1'b1};
    plus_col = (mh << 1) | ~(xv | ph);
    minus_col = ph & xv;

    bp = prefix_best;
    if (eq[bp] || mh[bp]) begin
      prefix_best = bp + 1'b1;
    end else if (ph[bp]) begin
      // The distance at the old prefix end just went past the threshold;
      // walk down the new column until it is back within it.
      score = maxd_reg + 1;
      idx = bp;
      found = 1'b0;
      while (idx > 0 && !found) begin
        idx--;
        if (plus_col[idx]) begin
          score--;
          if (score <= maxd_reg) begin
            prefix_best = idx[PREFIX_W-1:0];
            found = 1'b1;
          end
        end else if (minus_col[idx]) begin
          score++;
        end
      end
      if (!found) begin
        prefix_best = '0;
        col_ended = 1'b1;
        res.outcome = OUTCOME_FAILURE;
        res.prefix_end = '0;
        return res;
      end
    end

    if (prefix_best >= m) begin
      col_ended = 1'b1;
      res.outcome = OUTCOME_SUCCESS;
    end else begin
      res.outcome = OUTCOME_CONTINUE;
    end
    res.prefix_end = prefix_best;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. A beat stays on the bus, unchanged, until the block takes
  // it; only then may the next one appear or an idle burst begin.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        // This cycle stays empty, and so do send_gap more after it.
        send_gap = $urandom_range(0, 17);
        in_valid_i <= 1'b0;
      end else begin
        in_data_i <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // Output stall: random bursts, their length drawn into stall_left.
  always @(negedge clk_i) begin
    if (stall_left == 0 && rst_ni && $urandom_range(99) < idle_pct)
      stall_left = $urandom_range(1, 18);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge. An accepted input
  // beat is run through the predictor at once; an accepted result beat is
  // checked against the oldest result owed. The watchdog ends the run when
  // nothing moves for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    logic      in_fire;
    logic      out_fire;
    out_beat_t want;

    in_fire = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    in_taken <= in_fire;

    if (in_fire) begin
      results_due.push_back(advance_column(in_data_i));
      beats_open--;
    end

    if (out_fire) begin
      if (results_due.size() == 0) begin
        $error("result beat with no item outstanding: outcome %0d prefix_end %0d",
               out_data_o.outcome, out_data_o.prefix_end);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_data_o.outcome !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, out_data_o.outcome);
          mismatches++;
        end
        if (out_data_o.prefix_end !== want.prefix_end) begin
          $error("prefix_end: expected %0d, actual %0d",
                 want.prefix_end, out_data_o.prefix_end);
          mismatches++;
        end
      end
    end

    if (!rst_ni || in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // One register write on the config port, mirrored into the predictor. The
  // block is idle whenever this is called.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == REG_PATTERN_LENGTH)
      len_reg = data[PREFIX_W-1:0];
    else if (idx == REG_MAX_DISTANCE)
      maxd_reg = data[MD_W-1:0];
    else if (idx >= REG_EQ_BASE && idx < REG_EQ_BASE + NUM_EQ_REGS)
      eq_regs[idx - REG_EQ_BASE] = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_beat(input logic [1:0] sym, input logic wild, input logic rs);
    in_beat_t b;
    b.symbol = sym;
    b.is_wildcard = wild;
    b.restart = rs;
    pending_beats.push_back(b);
    beats_open++;
    beats_total++;
  endtask

  // Waits until every queued beat has been taken and every result is back.
  task automatic wait_idle();
    @(negedge clk_i);
    while (beats_open != 0 || results_due.size() != 0) @(negedge clk_i);
  endtask

  // Draws a new pattern and programs its match vectors and length. Bits past
  // the length are filled with junk, which the block must ignore. With
  // scramble set the vectors are pure noise, so one position may match
  // several symbols or none.
  task automatic program_pattern(input logic [PREFIX_W-1:0] raw, input logic scramble);
    logic [CFG_W-1:0] vec [NUM_EQ_REGS];
    int               m;
    m = eff_len(raw);
    for (int k = 0; k < NUM_EQ_REGS; k++) vec[k] = {$urandom, $urandom};
    for (int i = 0; i < m; i++) begin
      pat[i] = 2'($urandom);
      if (!scramble)
        for (int k = 0; k < NUM_EQ_REGS; k++) vec[k][i] = (pat[i] == k);
    end
    for (int k = 0; k < NUM_EQ_REGS; k++)
      write_reg(CFG_IDX_W'(REG_EQ_BASE + k), vec[k]);
    write_reg(REG_PATTERN_LENGTH, CFG_W'(raw));
  endtask

  // Queues one read: a restart, then the pattern with about the given number
  // of random substitutions (some by wildcards), insertions and deletions.
  // Edits within max_distance should lead to success, more of them usually
  // to failure.
  task automatic queue_read(input int edits);
    int         m, left, pos;
    logic       first, emit, advance, wild;
    logic [1:0] sym;
    m = eff_len(len_reg);
    left = edits;
    pos = 0;
    first = 1'b1;
    while (pos < m) begin
      emit = 1'b1;
      advance = 1'b1;
      wild = 1'b0;
      sym = pat[pos];
      if (left > 0 && $urandom_range(0, m - 1) < edits) begin
        left--;
        case ($urandom_range(0, 2))
          0: begin
            sym = 2'($urandom);
            wild = ($urandom_range(0, 2) == 0);
          end
          1: begin
            sym = 2'($urandom);
            advance = 1'b0;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
      if (emit) begin
        queue_beat(sym, wild, first);
        first = 1'b0;
      end
      if (advance) pos++;
    end
    if (first) queue_beat(2'($urandom), 1'b0, 1'b1);
  endtask

  // Short runs of loose symbols; most carry no restart, so they either go on
  // with the current column or get rejected after it has ended.
  task automatic queue_noise(input int count);
    repeat (count)
      queue_beat(2'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int                  m;
    int                  edits;
    int                  pick;
    logic [PREFIX_W-1:0] raw;
    logic [MD_W-1:0]     maxd;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 20;

    // Straight out of reset: all match vectors are zero and the threshold is
    // zero, so the first symbol fails and the next one is rejected.
    queue_beat(2'd0, 1'b0, 1'b0);
    queue_beat(2'd1, 1'b0, 1'b0);
    wait_idle();

    // An eight-symbol pattern A C G T T G C A, with junk above bit 7 of the
    // match vectors, and a threshold of one. Writes to the unused register
    // slots must leave everything alone.
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    write_reg(REG_MAX_DISTANCE, 64'd1);
    write_reg(REG_EQ_BASE, 64'hA5A5_0000_0000_0081);
    write_reg(CFG_IDX_W'(REG_EQ_BASE + 1), 64'hFFFF_FFFF_FFFF_FF42);
    write_reg(CFG_IDX_W'(REG_EQ_BASE + 2), 64'h0123_4567_89AB_CD24);
    write_reg(CFG_IDX_W'(REG_EQ_BASE + 3), 64'h8000_0000_0000_0018);
    for (int r = REG_EQ_BASE + NUM_EQ_REGS; r < (1 << CFG_IDX_W); r++)
      write_reg(r[CFG_IDX_W-1:0], {$urandom, $urandom});
    pat = '{default: '0};
    // One wildcard in place of G is a single mismatch, so the read succeeds;
    // the symbol after it is rejected.
    queue_beat(2'd0, 1'b0, 1'b1);
    queue_beat(2'd1, 1'b0, 1'b0);
    queue_beat(2'd2, 1'b1, 1'b0);
    queue_beat(2'd3, 1'b0, 1'b0);
    queue_beat(2'd3, 1'b0, 1'b0);
    queue_beat(2'd2, 1'b0, 1'b0);
    queue_beat(2'd1, 1'b0, 1'b0);
    queue_beat(2'd0, 1'b0, 1'b0);
    queue_beat(2'd0, 1'b0, 1'b0);
    // A run of T drifts away from the pattern and ends in failure.
    queue_beat(2'd3, 1'b0, 1'b1);
    queue_beat(2'd3, 1'b0, 1'b0);
    queue_beat(2'd3, 1'b0, 1'b0);
    queue_beat(2'd3, 1'b0, 1'b0);
    queue_beat(2'd3, 1'b0, 1'b0);
    wait_idle();

    // A length of zero acts as one; with the largest threshold the restart
    // alone completes the prefix. Then the longest length value, which acts
    // as the full width.
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_MAX_DISTANCE, 64'd63);
    queue_beat(2'd2, 1'b0, 1'b1);
    queue_beat(2'd1, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd127);
    queue_beat(2'd0, 1'b0, 1'b1);
    wait_idle();

    // An all-A pattern of full length grows the prefix; lowering the length
    // under the current prefix end makes the next symbol succeed at once.
    write_reg(REG_PATTERN_LENGTH, 64'd64);
    write_reg(REG_MAX_DISTANCE, 64'd5);
    write_reg(REG_EQ_BASE, '1);
    queue_beat(2'd0, 1'b0, 1'b1);
    queue_beat(2'd0, 1'b0, 1'b0);
    queue_beat(2'd0, 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    queue_beat(2'd0, 1'b0, 1'b0);
    wait_idle();

    // Random phases. Each one reprograms some registers while the block is
    // idle, then sends a handful of reads mixed with loose symbols.
    while (beats_total < ITEM_TARGET) begin
      if (beats_total >= CALM_FROM) begin
        idle_pct = 0;
      end else begin
        pick = $urandom_range(0, 2);
        idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
      end

      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // New pattern. Most lengths are short, some long, a few at or past
        // the limits.
        pick = $urandom_range(0, 19);
        if (pick == 0) raw = '0;
        else if (pick == 1) raw = PREFIX_W'($urandom_range(65, 127));
        else if (pick < 4) raw = PREFIX_W'(PATTERN_BITS);
        else if (pick < 8) raw = PREFIX_W'($urandom_range(17, 63));
        else raw = PREFIX_W'($urandom_range(1, 16));
        m = eff_len(raw);
        pick = $urandom_range(0, 9);
        if (pick == 0) maxd = '0;
        else if (pick == 1) maxd = '1;
        else if (pick == 2) maxd = MD_W'($urandom_range(0, 63));
        else maxd = MD_W'($urandom_range(0, m / 4 + 1));
        program_pattern(raw, $urandom_range(0, 9) == 0);
        write_reg(REG_MAX_DISTANCE, CFG_W'(maxd));
      end else if (pick < 9) begin
        // Threshold change only; the column carries on if not restarted.
        write_reg(REG_MAX_DISTANCE, CFG_W'($urandom_range(0, 63)));
      end else begin
        // Lower or equal length only, which may cut below the current prefix end.
        write_reg(REG_PATTERN_LENGTH, CFG_W'($urandom_range(1, eff_len(len_reg))));
      end

      repeat ($urandom_range(2, 5)) begin
        queue_noise($urandom_range(0, 2));
        if ($urandom_range(0, 9) < 6) edits = $urandom_range(0, maxd_reg);
        else edits = maxd_reg + $urandom_range(1, 4);
        queue_read(edits);
      end
      queue_noise($urandom_range(0, 2));
      wait_idle();
    end

    // Everything is back; give the block time to show any stray result.
    wait_idle();
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
